// ===== rtl/slpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpg_pkg: shared types and constants
// Widths, register indexes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package slpg_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int REG_W      = 31;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 64;
    localparam int PEN_W      = 63;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int NUM_W      = 63;      // w * |x| fits in 31 + 32 bits
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 63;
    localparam int CNT_W      = 6;

    localparam logic [REG_W-1:0] WEIGHT_RST = REG_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] SMOOTH_RST = REG_W'(100) << FRAC_BITS;

    localparam logic [0:0] REG_WEIGHT = 1'b0;
    localparam logic [0:0] REG_SMOOTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;       // capture input, start root
        logic sqrt_step;  // one root digit
        logic mul;        // form products
        logic div_step;   // one quotient bit
        logic acc;        // update sum and gradient
        logic out_take;   // result taken, clear sum if last
    } t_cmd;

    typedef struct packed {
        logic cnt_done;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/slpg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpg_ctrl: sequencing controller
// Steps root, multiply, divide and accumulate phases for one request.
// ----------------------------------------------------------------------------
module slpg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_stall,
    input  wire slpg_pkg::t_status i_status,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output slpg_pkg::t_cmd         o_cmd
);
    slpg_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slpg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            slpg_pkg::ST_IDLE: if (i_in_valid) n_state = slpg_pkg::ST_SQRT;
            slpg_pkg::ST_SQRT: if (i_status.cnt_done) n_state = slpg_pkg::ST_MUL;
            slpg_pkg::ST_MUL:  n_state = slpg_pkg::ST_DIV;
            slpg_pkg::ST_DIV:  if (i_status.cnt_done) n_state = slpg_pkg::ST_ACC;
            slpg_pkg::ST_ACC:  n_state = slpg_pkg::ST_OUT;
            slpg_pkg::ST_OUT: begin
                if (!i_out_stall) n_state = i_in_valid ? slpg_pkg::ST_SQRT : slpg_pkg::ST_IDLE;
            end
            default: n_state = slpg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            slpg_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            slpg_pkg::ST_SQRT: o_cmd.sqrt_step = 1'b1;
            slpg_pkg::ST_MUL:  o_cmd.mul = 1'b1;
            slpg_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            slpg_pkg::ST_ACC:  o_cmd.acc = 1'b1;
            slpg_pkg::ST_OUT: begin
                o_out_valid    = 1'b1;
                o_in_stall     = i_out_stall;
                o_cmd.out_take = !i_out_stall;
                o_cmd.load     = !i_out_stall && i_in_valid;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/slpg_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpg_dp: arithmetic datapath
// Bit-pair square root, restoring divider, products and saturating sums.
// ----------------------------------------------------------------------------
module slpg_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire slpg_pkg::t_cmd                i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_sel,
    input  wire logic [slpg_pkg::REG_W-1:0]    i_cfg_data,
    input  wire logic signed [slpg_pkg::DATA_W-1:0] i_x_value,
    input  wire logic signed [slpg_pkg::DATA_W-1:0] i_grad_in,
    input  wire logic                          i_last_in,
    output slpg_pkg::t_status                  o_status,
    output logic signed [slpg_pkg::DATA_W-1:0] o_grad_out,
    output logic [slpg_pkg::PEN_W-1:0]         o_penalty_sum,
    output logic                               o_last_out
);
    localparam int RW = slpg_pkg::RAD_W;
    localparam int NW = slpg_pkg::NUM_W;

    logic [slpg_pkg::REG_W-1:0]  r_weight, r_smooth;
    logic [slpg_pkg::DATA_W-1:0] r_ax;
    logic                        r_neg, r_last;
    logic signed [slpg_pkg::DATA_W-1:0] r_grad;
    logic [RW-1:0]               r_rem;     // root remainder
    logic [RW-1:0]               r_rad;     // radicand bits still to shift in
    logic [slpg_pkg::ROOT_W-1:0] r_root;
    logic [NW-1:0]               r_num;     // dividend shift / quotient
    logic [slpg_pkg::ROOT_W:0]   r_drem;    // divider remainder
    logic [NW-1:0]               r_pen_prod;
    logic [slpg_pkg::SUM_W-1:0]  r_sum;
    logic [slpg_pkg::CNT_W-1:0]  r_cnt;
    logic signed [slpg_pkg::DATA_W-1:0] r_gout;
    logic [slpg_pkg::PEN_W-1:0]  r_pout;

    logic [RW-1:0] n_rem_sh, n_trial;
    logic [slpg_pkg::ROOT_W:0] n_dsh;
    logic [slpg_pkg::ROOT_W:0] n_dsub;
    logic [slpg_pkg::DATA_W-1:0] n_ax;
    logic [slpg_pkg::SUM_W-1:0] n_sat_sum, n_pen;
    logic signed [slpg_pkg::DATA_W+1:0] n_gsum;
    logic [slpg_pkg::DATA_W-1:0] n_gmag;
    logic n_zero_root;

    assign n_ax = i_x_value[slpg_pkg::DATA_W-1] ? slpg_pkg::DATA_W'(-i_x_value)
                                                : i_x_value;
    // root digit: remainder gets next bit pair, trial = 4*root + 1
    assign n_rem_sh = {r_rem[RW-3:0], r_rad[RW-1:RW-2]};
    assign n_trial  = {(RW-slpg_pkg::ROOT_W-2)'(0), r_root, 2'b01};
    // divide step
    assign n_dsh    = {r_drem[slpg_pkg::ROOT_W-1:0], r_num[NW-1]};
    assign n_dsub   = n_dsh - {1'b0, r_root};
    assign n_zero_root = (r_root == '0);
    assign n_gmag   = n_zero_root ? '0 : r_num[slpg_pkg::DATA_W-1:0];
    assign n_gsum   = r_neg ? (slpg_pkg::DATA_W+2)'(r_grad) - $signed({2'b00, n_gmag})
                            : (slpg_pkg::DATA_W+2)'(r_grad) + $signed({2'b00, n_gmag});
    assign n_pen    = slpg_pkg::SUM_W'(r_pen_prod >> slpg_pkg::FRAC_BITS);
    assign n_sat_sum = (n_pen > {1'b0, {(slpg_pkg::SUM_W-1){1'b1}}} - r_sum)
                     ? {1'b0, {(slpg_pkg::SUM_W-1){1'b1}}} : r_sum + n_pen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= slpg_pkg::WEIGHT_RST;
            r_smooth <= slpg_pkg::SMOOTH_RST;
            r_sum    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_sel == slpg_pkg::REG_WEIGHT) r_weight <= i_cfg_data;
            if (i_cfg_we && i_cfg_sel == slpg_pkg::REG_SMOOTH) r_smooth <= i_cfg_data;
            if (i_cmd.acc) r_sum <= n_sat_sum;
            else if (i_cmd.out_take && r_last) r_sum <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load || i_cmd.mul) begin
            r_cnt <= '0;
        end else if (i_cmd.sqrt_step || i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax   <= n_ax;
            r_neg  <= i_x_value[slpg_pkg::DATA_W-1];
            r_grad <= i_grad_in;
            r_last <= i_last_in;
            r_rad  <= RW'(n_ax) * RW'(n_ax)
                    + (RW'(r_smooth) << slpg_pkg::FRAC_BITS);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= r_rad << 2;
            if (n_rem_sh >= n_trial) begin
                r_rem  <= n_rem_sh - n_trial;
                r_root <= {r_root[slpg_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh;
                r_root <= {r_root[slpg_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul) begin
            r_num      <= NW'(r_weight) * NW'(r_ax);
            r_pen_prod <= NW'(r_weight) * NW'(r_root);
            r_drem     <= '0;
        end
        if (i_cmd.div_step) begin
            if (!n_dsub[slpg_pkg::ROOT_W]) begin
                r_drem <= n_dsub;
                r_num  <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_drem <= n_dsh;
                r_num  <= {r_num[NW-2:0], 1'b0};
            end
        end
        if (i_cmd.acc) begin
            if (n_gsum > (slpg_pkg::DATA_W+2)'(32'sh7fffffff))
                r_gout <= 32'sh7fffffff;
            else if (n_gsum < -(slpg_pkg::DATA_W+2)'(34'sh80000000))
                r_gout <= 32'sh80000000;
            else
                r_gout <= n_gsum[slpg_pkg::DATA_W-1:0];
            r_pout <= n_sat_sum[slpg_pkg::PEN_W-1:0];
        end
    end

    assign o_status.cnt_done = i_cmd.sqrt_step ? (r_cnt == slpg_pkg::CNT_W'(slpg_pkg::SQRT_STEPS-1))
                                               : (r_cnt == slpg_pkg::CNT_W'(slpg_pkg::DIV_STEPS-1));
    assign o_grad_out    = r_gout;
    assign o_penalty_sum = r_pout;
    assign o_last_out    = r_last;
endmodule
`default_nettype wire

// ===== rtl/smooth_l1_penalty_gradient.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smooth_l1_penalty_gradient: pseudo-Huber penalty and gradient
// Per element: s = isqrt(x*x + smoothing<<F), grad += w*x/s, sum += w*s>>F.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | i_in_valid/o_in_stall | x_value, grad_in, last_in
//  out     | output    | o_out_valid/i_out_stall | grad_out, penalty_sum, last_out
//  cfg     | input     | i_cfg_valid/o_cfg_ready | cfg_index, cfg_data
//
// Each request runs 32 root digits, 1 multiply, 63 divide bits and 1 accumulate,
// then holds in the output state; the two bit-serial loops dominate its run time.
// Reset (sync, active low) loads weight 1.0, smoothing 100.0, clears the sum.
// A held result blocks the next request until taken; hold payload on stall.
// The sum clears once a result marked last is taken.
// ----------------------------------------------------------------------------
module smooth_l1_penalty_gradient (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic signed [31:0]   i_x_value,
    input  wire logic signed [31:0]   i_grad_in,
    input  wire logic                 i_last_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic signed [31:0]        o_grad_out,
    output logic [62:0]               o_penalty_sum,
    output logic                      o_last_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [31:0]          i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);
    slpg_pkg::t_cmd    w_cmd;
    slpg_pkg::t_status w_status;
    logic w_cfg_we;

    // Config always taken; indexes beyond the two registers are dropped.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we = i_cfg_valid && (i_cfg_index[31:1] == '0);

    slpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    slpg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_sel     (i_cfg_index[0]),
        .i_cfg_data    (i_cfg_data[slpg_pkg::REG_W-1:0]),
        .i_x_value     (i_x_value),
        .i_grad_in     (i_grad_in),
        .i_last_in     (i_last_in),
        .o_status      (w_status),
        .o_grad_out    (o_grad_out),
        .o_penalty_sum (o_penalty_sum),
        .o_last_out    (o_last_out)
    );
endmodule
`default_nettype wire

// ===== rtl/slpg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpg_checker: port-level checks
// Watches handshakes and result ordering on the top-level ports.
// ----------------------------------------------------------------------------
module slpg_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic signed [31:0] o_grad_out,
    input wire logic [62:0] o_penalty_sum
);
    // A request accepted in idle produces no result next cycle.
    ap_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> !o_out_valid)
        else $error("result too early");
    // Result held while stalled.
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_grad_out)
                                          && $stable(o_penalty_sum)))
        else $error("result changed under stall");
    // While a result waits under stall no new request is taken.
    ap_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request taken with result pending");
endmodule

bind smooth_l1_penalty_gradient slpg_checker u_slpg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .o_grad_out(o_grad_out), .o_penalty_sum(o_penalty_sum)
);
`default_nettype wire
